// ----- src/aspect_fit_rectangle_assert.svh -----
// ----------------------------------------------------------------------------
// aspect_fit_rectangle_assert
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASPECT_FIT_RECTANGLE_ASSERT_SVH
`define ASPECT_FIT_RECTANGLE_ASSERT_SVH

// Same-cycle implication, masked while reset is asserted.
`define AFR_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define AFR_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define AFR_ASSERT_ALWAYS(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/afr_pkg.sv -----
// ----------------------------------------------------------------------------
// afr_pkg
// Shared widths and request/result types of the aspect fit block.
// ----------------------------------------------------------------------------
package afr_pkg;

    localparam int DIM_BITS = 15;

    typedef struct packed {
        logic [DIM_BITS-1:0] source_width;
        logic [DIM_BITS-1:0] source_height;
        logic [DIM_BITS-1:0] target_width;
        logic [DIM_BITS-1:0] target_height;
    } afr_req_t;

    typedef struct packed {
        logic                fit_valid;
        logic [DIM_BITS-1:0] fit_x;
        logic [DIM_BITS-1:0] fit_y;
        logic [DIM_BITS-1:0] fit_width;
        logic [DIM_BITS-1:0] fit_height;
    } afr_rsp_t;

endpackage

// ----- src/aspect_fit_rectangle.sv -----
// ----------------------------------------------------------------------------
// aspect_fit_rectangle
// Largest centered rectangle of the source aspect ratio inside a target area.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one request: source and target sizes.
//   m_valid/m_ready/m_data return one result per request, in order:
//   fit_valid, offsets and size of the fitted rectangle.
//   A request with any zero dimension gives fit_valid = 0 and zero fields.
// Pipeline:
//   One multiply stage, one compare/select stage, one restoring divider
//   stage per quotient bit, and one clamp/offset output stage.
//   One request is accepted per cycle while the output is not stalled.
// Reset (aresetn low, synchronous) empties the pipeline; in-flight requests
// are dropped and m_valid goes low.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module aspect_fit_rectangle
    import afr_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  afr_req_t s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output afr_rsp_t m_data
);

    localparam int D = DIM_BITS;

    typedef struct packed {
        logic         nz;
        logic         wide;
        logic [D-1:0] rem;
        logic [D-1:0] sr;   // low dividend bits out the top, quotient bits in
        logic [D-1:0] div;
        logic [D-1:0] tw;
        logic [D-1:0] th;
    } dv_t;

    logic ce;

    // stage 1: products
    logic           s1_vld_reg;
    logic           s1_nz_reg;
    logic [2*D-1:0] s1_a_reg;     // sw * th
    logic [2*D-1:0] s1_b_reg;     // tw * sh
    logic [D-1:0]   s1_sw_reg;
    logic [D-1:0]   s1_sh_reg;
    logic [D-1:0]   s1_tw_reg;
    logic [D-1:0]   s1_th_reg;

    // divider stages, entry 0 is the compare/select stage
    logic [D:0] dv_vld_reg;
    dv_t        dv_reg  [0:D];
    dv_t        dv_next [1:D];
    dv_t        dv_init;

    logic     m_valid_reg;
    afr_rsp_t m_data_reg;
    afr_rsp_t m_data_next;

    assign ce      = !m_valid_reg || m_ready;
    assign s_ready = ce;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (ce) begin
            s1_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            s1_nz_reg <= (s_data.source_width != '0) && (s_data.source_height != '0) &&
                         (s_data.target_width != '0) && (s_data.target_height != '0);
            s1_a_reg  <= s_data.source_width * s_data.target_height;
            s1_b_reg  <= s_data.target_width * s_data.source_height;
            s1_sw_reg <= s_data.source_width;
            s1_sh_reg <= s_data.source_height;
            s1_tw_reg <= s_data.target_width;
            s1_th_reg <= s_data.target_height;
        end
    end

    // Wider source: height = round(tw*sh/sw); else width = round(th*sw/sh).
    always_comb begin
        logic [2*D-1:0] num;
        logic           wide;
        wide = s1_a_reg > s1_b_reg;
        if (wide) begin
            num         = s1_b_reg + {{(D+1){1'b0}}, s1_sw_reg[D-1:1]};
            dv_init.div = s1_sw_reg;
        end else begin
            num         = s1_a_reg + {{(D+1){1'b0}}, s1_sh_reg[D-1:1]};
            dv_init.div = s1_sh_reg;
        end
        dv_init.nz   = s1_nz_reg;
        dv_init.wide = wide;
        dv_init.rem  = num[2*D-1:D];
        dv_init.sr   = num[D-1:0];
        dv_init.tw   = s1_tw_reg;
        dv_init.th   = s1_th_reg;
    end

    // One restoring division step per stage; quotient fits D bits because
    // the dividend stays below divisor * 2^D.
    always_comb begin
        for (int k = 0; k < D; k++) begin
            logic [D:0] trial;
            logic [D:0] diff;
            logic       ge;
            trial = {dv_reg[k].rem, dv_reg[k].sr[D-1]};
            diff  = trial - {1'b0, dv_reg[k].div};
            ge    = trial >= {1'b0, dv_reg[k].div};
            dv_next[k+1]     = dv_reg[k];
            dv_next[k+1].rem = ge ? diff[D-1:0] : trial[D-1:0];
            dv_next[k+1].sr  = {dv_reg[k].sr[D-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_vld_reg <= '0;
        end else if (ce) begin
            dv_vld_reg <= {dv_vld_reg[D-1:0], s1_vld_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            dv_reg[0] <= dv_init;
            for (int k = 1; k <= D; k++) begin
                dv_reg[k] <= dv_next[k];
            end
        end
    end

    // clamp to [1, limit] and center
    always_comb begin
        logic [D-1:0] q;
        logic [D-1:0] lim;
        logic [D-1:0] qc;
        logic [D-1:0] w;
        logic [D-1:0] h;
        logic [D-1:0] dx;
        logic [D-1:0] dy;
        q   = dv_reg[D].sr;
        lim = dv_reg[D].wide ? dv_reg[D].th : dv_reg[D].tw;
        if (q == '0) begin
            qc = {{(D-1){1'b0}}, 1'b1};
        end else if (q > lim) begin
            qc = lim;
        end else begin
            qc = q;
        end
        w  = dv_reg[D].wide ? dv_reg[D].tw : qc;
        h  = dv_reg[D].wide ? qc : dv_reg[D].th;
        dx = dv_reg[D].tw - w;
        dy = dv_reg[D].th - h;
        if (dv_reg[D].nz) begin
            m_data_next.fit_valid  = 1'b1;
            m_data_next.fit_x      = {1'b0, dx[D-1:1]};
            m_data_next.fit_y      = {1'b0, dy[D-1:1]};
            m_data_next.fit_width  = w;
            m_data_next.fit_height = h;
        end else begin
            m_data_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ce) begin
            m_valid_reg <= dv_vld_reg[D];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

// ----- src/afr_checker.sv -----
// ----------------------------------------------------------------------------
// afr_checker
// Port-level checks of the aspect fit block, bound to the top level.
// ----------------------------------------------------------------------------
`include "aspect_fit_rectangle_assert.svh"

module afr_checker
    import afr_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     m_valid,
    input logic     m_ready,
    input afr_rsp_t m_data
);

    `AFR_ASSERT_ALWAYS(a_rst_empty, !aresetn, !m_valid, "result valid right after reset")
    `AFR_ASSERT_NEXT(a_hold_valid, m_valid && !m_ready, m_valid, "stalled result dropped")
    `AFR_ASSERT_NEXT(a_hold_data, m_valid && !m_ready, $stable(m_data), "stalled result changed")
    `AFR_ASSERT_NOW(a_fit_size, m_valid && m_data.fit_valid,
                    (m_data.fit_width != '0) && (m_data.fit_height != '0),
                    "fitted size is zero")
    `AFR_ASSERT_NOW(a_bad_zero, m_valid && !m_data.fit_valid,
                    (m_data.fit_x == '0) && (m_data.fit_y == '0) &&
                    (m_data.fit_width == '0) && (m_data.fit_height == '0),
                    "invalid result not zero")

endmodule

bind aspect_fit_rectangle afr_checker u_afr_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ----- verif/tb_aspect_fit_rectangle.sv -----
// ----------------------------------------------------------------------------
// tb_aspect_fit_rectangle
// Self-checking bench for the aspect fit block: directed corner requests and
// random size requests go in through a queued driver, and each result is
// compared field by field with an in-order prediction of the fitted rectangle.
// ----------------------------------------------------------------------------
module tb_aspect_fit_rectangle;
    import afr_pkg::*;

    localparam int DIM_MAX  = (1 << DIM_BITS) - 1;
    localparam int LATENCY  = DIM_BITS + 3;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    afr_req_t s_data;
    logic     m_valid;
    logic     m_ready;
    afr_rsp_t m_data;

    afr_req_t pending_reqs[$];
    afr_rsp_t fit_expect[$];

    int  send_idle_pct;
    int  recv_idle_pct;
    bit  out_hold;
    bit  req_taken;
    int  reqs_queued;
    int  reqs_accepted;
    int  results_checked;
    int  zero_dim_results;
    int  backpressure_cycles;
    int  mismatches;

    aspect_fit_rectangle i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // Letterbox/pillarbox fit, exact in 64 bits.
    function automatic afr_rsp_t fit_rect(afr_req_t r);
        logic [63:0] sw, sh, tw, th, w, h;
        afr_rsp_t    f;
        f  = '0;
        sw = 64'(r.source_width);
        sh = 64'(r.source_height);
        tw = 64'(r.target_width);
        th = 64'(r.target_height);
        if (sw == 0 || sh == 0 || tw == 0 || th == 0) begin
            return f;
        end
        if (sw * th > tw * sh) begin
            w = tw;
            h = (tw * sh + (sw >> 1)) / sw;
        end else begin
            // equal ratios land here and fill the whole target
            h = th;
            w = (th * sw + (sh >> 1)) / sh;
        end
        if (w < 1) w = 1;
        if (w > tw) w = tw;
        if (h < 1) h = 1;
        if (h > th) h = th;
        f.fit_valid  = 1'b1;
        f.fit_x      = DIM_BITS'((tw - w) >> 1);
        f.fit_y      = DIM_BITS'((th - h) >> 1);
        f.fit_width  = DIM_BITS'(w);
        f.fit_height = DIM_BITS'(h);
        return f;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string field, input int unsigned got,
                               input int unsigned want);
        if (got != want) begin
            report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                      results_checked, field, got, want));
        end
    endtask

    task automatic queue_req(input int sw, input int sh, input int tw, input int th);
        afr_req_t r;
        r.source_width  = DIM_BITS'(sw);
        r.source_height = DIM_BITS'(sh);
        r.target_width  = DIM_BITS'(tw);
        r.target_height = DIM_BITS'(th);
        pending_reqs = {pending_reqs, r};
        reqs_queued++;
    endtask

    // Mix of zero, max, small, mid-size and full-range dimensions.
    function automatic int rand_dim();
        int pick;
        pick = $urandom_range(19);
        if (pick == 0) return 0;
        if (pick == 1) return DIM_MAX;
        if (pick < 6) return $urandom_range(64, 1);
        if (pick < 10) return $urandom_range(2048, 1);
        return $urandom_range(DIM_MAX, 1);
    endfunction

    task automatic queue_random(input int count);
        int a, b, ks, kt;
        repeat (count) begin
            if ($urandom_range(99) < 20) begin
                // same aspect ratio on both sides
                a  = $urandom_range(40, 1);
                b  = $urandom_range(40, 1);
                ks = $urandom_range(DIM_MAX / ((a > b) ? a : b), 1);
                kt = $urandom_range(DIM_MAX / ((a > b) ? a : b), 1);
                queue_req(a * ks, b * ks, a * kt, b * kt);
            end else begin
                queue_req(rand_dim(), rand_dim(), rand_dim(), rand_dim());
            end
        end
    endtask

    task automatic wait_drained();
        while (reqs_accepted != reqs_queued || fit_expect.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Request driver: holds the payload until accepted, then maybe idles.
    always @(negedge aclk) begin : drive_req
        logic     offer;
        afr_req_t nxt;
        if (aresetn) begin
            offer     = s_valid && !req_taken;
            req_taken = 1'b0;
            nxt       = s_data;
            if (!offer && pending_reqs.size() != 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                nxt   = pending_reqs.pop_front();
                offer = 1'b1;
            end
            s_valid <= offer;
            s_data  <= nxt;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn || out_hold) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: predict on request accept, check on result accept.
    always @(posedge aclk) begin : watch_ports
        afr_rsp_t want;
        if (aresetn) begin
            if (s_valid && !s_ready) begin
                backpressure_cycles++;
            end
            if (s_valid && s_ready) begin
                fit_expect = {fit_expect, fit_rect(s_data)};
                req_taken = 1'b1;
                reqs_accepted++;
            end
            if (m_valid && m_ready) begin
                if (fit_expect.size() == 0) begin
                    report_mismatch("result with no request outstanding");
                end else begin
                    want = fit_expect.pop_front();
                    check_field("fit_valid", m_data.fit_valid, want.fit_valid);
                    check_field("fit_x", m_data.fit_x, want.fit_x);
                    check_field("fit_y", m_data.fit_y, want.fit_y);
                    check_field("fit_width", m_data.fit_width, want.fit_width);
                    check_field("fit_height", m_data.fit_height, want.fit_height);
                    if (!want.fit_valid) zero_dim_results++;
                    results_checked++;
                end
            end
        end
    end

    initial begin
        #3000000;
        $display("Timeout: %0d results still outstanding", fit_expect.size());
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        aclk          = 1'b0;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        m_ready       = 1'b0;
        out_hold      = 1'b0;
        req_taken     = 1'b0;
        send_idle_pct = 30;
        recv_idle_pct = 73;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed corners
        queue_req(DIM_MAX, DIM_MAX, DIM_MAX, DIM_MAX);
        queue_req(1, 1, 1, 1);
        queue_req(0, 0, 0, 0);
        queue_req(0, 480, 1920, 1080);
        queue_req(640, 0, 1920, 1080);
        queue_req(640, 480, 0, 1080);
        queue_req(640, 480, 1920, 0);
        queue_req(1920, 1080, 1280, 1024);
        queue_req(1080, 1920, 1920, 1080);
        queue_req(640, 480, 1920, 1080);
        queue_req(DIM_MAX, 1, 1, 1);              // height rounds to 0, clamped up
        queue_req(1, DIM_MAX, 1, 1);              // width rounds to 0, clamped up
        queue_req(DIM_MAX, 1, DIM_MAX, DIM_MAX);
        queue_req(1, DIM_MAX, DIM_MAX, DIM_MAX);
        queue_req(2, 1, 3, 3);                    // exact half rounds up
        queue_req(1, 1, 5, 4);                    // odd leftover floors
        queue_req(3, 2, DIM_MAX, 1);
        queue_req(3, 7, DIM_MAX, DIM_MAX);
        queue_req(16'h5555, 16'h2aaa, 16'h2aaa, 16'h5555);
        queue_req(16'h2aaa, 16'h5555, 16'h5555, 16'h2aaa);
        queue_req(4, 3, 400, 300);
        queue_random(200);
        wait_drained();

        send_idle_pct = 73;
        recv_idle_pct = 30;
        queue_random(220);
        wait_drained();

        // No idling, plus a long output stall to back the pipeline up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(210);
        out_hold = 1'b1;
        repeat (300) @(posedge aclk);
        out_hold = 1'b0;
        wait_drained();

        repeat (2 * LATENCY) @(posedge aclk);

        $display("Checked %0d results of %0d requests, %0d with a zero dimension.",
                 results_checked, reqs_accepted, zero_dim_results);
        $display("Three idle mixes and one long output stall; input held off %0d cycles.",
                 backpressure_cycles);
        if (mismatches == 0 && fit_expect.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
